[rtl/dhtu_pkg.sv]
`default_nettype none
package dhtu_pkg;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ADC,
    KIND_FLOW,
    KIND_SCALER
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_HEADER,
    ERR_TIME,
    ERR_BOARD,
    ERR_WAVE,
    ERR_CODE,
    ERR_TYPE
  } err_e;

  typedef enum logic [1:0] {
    TYPE_INVALID,
    TYPE_WAVE,
    TYPE_INFO,
    TYPE_ADC
  } dtype_e;

  localparam logic       OP_HEADER = 1'b0;

  localparam logic [15:0] TAG_A = 16'h03e1;
  localparam logic [15:0] TAG_B = 16'h04e1;
  localparam logic [15:0] TAG_C = 16'h05e1;
  localparam logic [15:0] TAG_D = 16'h06e1;

  localparam logic [3:0] INFO_PAUSE  = 4'd2;
  localparam logic [3:0] INFO_RESUME = 4'd3;
  localparam logic [3:0] INFO_MID    = 4'd4;
  localparam logic [3:0] INFO_HIGH   = 4'd5;
  localparam logic [3:0] INFO_DISC   = 4'd6;
  localparam logic [3:0] INFO_SCALER = 4'd8;

  localparam logic [1:0] SCALER_REPORT_SLOT = 2'd2;

  localparam logic       CFG_SPACING    = 1'b0;
  localparam logic       CFG_WARN_LIMIT = 1'b1;

  localparam logic [15:0] SPACING_RESET    = 16'd2000;
  localparam logic [7:0]  WARN_LIMIT_RESET = 8'd16;

  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic        warn;
    logic [63:0] raw_time;
    logic [63:0] slow_time;
    logic [63:0] disc_time;
    logic [63:0] value;
    logic [6:0]  board;
    logic [5:0]  channel;
    logic        vernier;
    logic        gain_range;
    logic        paused;
  } rec_t;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       corr;
    logic       sweep;
    logic       sweep_last;
    logic [3:0] sweep_idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic adc_ok;
    logic disc_ok;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

[rtl/detector_hit_timestamp_unpacker.sv]
`default_nettype none
// Unpacks header and data items into hit, flow and scaler records, one
// result item per input item. Header, info and error items pass through
// capture, memory read, execute and output load; adc hits add a step
// that applies the multiplex correction after the group read-modify-write,
// and discriminator items add a sweep in which the 16 fast-time entries
// of a group are written one per cycle through the fast-time memory's
// single write port. The output register holds a finished result while
// the next item is accepted; a stalled output adds its stall time.
// No clearing pass is needed after reset: per-row valid bits mark the
// stores as zero until written.
module detector_hit_timestamp_unpacker #(
  parameter int BOARD_COUNT = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         opcode_i,
  input  wire  [31:0] word_a_i,
  input  wire  [31:0] word_b_i,
  input  wire  [31:0] word_c_i,
  input  wire  [31:0] word_d_i,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [2:0]  error_code_o,
  output logic        multiplex_warning_o,
  output logic [63:0] raw_time_o,
  output logic [63:0] slow_time_o,
  output logic [63:0] disc_time_o,
  output logic [63:0] value_o,
  output logic [6:0]  board_o,
  output logic [5:0]  channel_o,
  output logic        vernier_o,
  output logic        gain_range_o,
  output logic        paused_o
);
  import dhtu_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  rec_t  rec;

  dhtu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dhtu_datapath #(
    .BOARD_COUNT (BOARD_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .word_a_i    (word_a_i),
    .word_b_i    (word_b_i),
    .word_c_i    (word_c_i),
    .word_d_i    (word_d_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rec_o   (rec)
  );

  assign record_kind_o       = rec.kind;
  assign error_code_o        = rec.err;
  assign multiplex_warning_o = rec.warn;
  assign raw_time_o          = rec.raw_time;
  assign slow_time_o         = rec.slow_time;
  assign disc_time_o         = rec.disc_time;
  assign value_o             = rec.value;
  assign board_o             = rec.board;
  assign channel_o           = rec.channel;
  assign vernier_o           = rec.vernier;
  assign gain_range_o        = rec.gain_range;
  assign paused_o            = rec.paused;

endmodule
`default_nettype wire

[rtl/dhtu_ctrl.sv]
`default_nettype none
module dhtu_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  dhtu_pkg::stat_t stat_i,
  output dhtu_pkg::cmd_t  cmd_o
);
  import dhtu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_CORR,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [3:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= 4'd0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_READ;
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          idx_q <= 4'd0;
          if (stat_i.adc_ok) state_q <= S_CORR;
          else if (stat_i.disc_ok) state_q <= S_SWEEP;
          else state_q <= S_FINISH;
        end
        S_CORR: state_q <= S_FINISH;
        S_SWEEP: begin
          idx_q <= idx_q + 4'd1;
          if (idx_q == 4'hf) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!stat_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_stall_o        = (state_q != S_IDLE);
    cmd_o             = '0;
    cmd_o.capture     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec        = (state_q == S_EXEC);
    cmd_o.corr        = (state_q == S_CORR);
    cmd_o.sweep       = (state_q == S_SWEEP);
    cmd_o.sweep_last  = (state_q == S_SWEEP) && (idx_q == 4'hf);
    cmd_o.sweep_idx   = idx_q;
    cmd_o.load_out    = (state_q == S_FINISH) && !stat_i.out_busy;
  end

`ifndef SYNTHESIS
  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_EXEC) else $error("read not followed by exec");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && state_q == S_IDLE) |=> state_q == S_READ) else $error("item lost");
  a_sweep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !stat_i.adc_ok && stat_i.disc_ok) |=>
      (state_q == S_SWEEP && idx_q == 4'd0)) else $error("sweep start");
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && idx_q == 4'hf) |=> state_q == S_FINISH) else $error("sweep end");
`endif

endmodule
`default_nettype wire

[rtl/dhtu_datapath.sv]
`default_nettype none
module dhtu_datapath #(
  parameter int BOARD_COUNT = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             opcode_i,
  input  wire  [31:0]     word_a_i,
  input  wire  [31:0]     word_b_i,
  input  wire  [31:0]     word_c_i,
  input  wire  [31:0]     word_d_i,
  input  wire             cfg_we_i,
  input  wire             cfg_index_i,
  input  wire  [15:0]     cfg_data_i,
  input  dhtu_pkg::cmd_t  cmd_i,
  output dhtu_pkg::stat_t stat_o,
  input  wire             out_stall_i,
  output logic            out_valid_o,
  output dhtu_pkg::rec_t  out_rec_o
);
  import dhtu_pkg::*;

  localparam int BW         = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
  localparam int FAST_DEPTH = BOARD_COUNT * 64;
  localparam int GRP_DEPTH  = BOARD_COUNT * 4;

  // captured item
  logic        op_q;
  logic [31:0] wa_q, wb_q, wc_q, wd_q;

  logic [63:0] rt_q, rt_d;
  logic [15:0] spacing_q;
  logic [7:0]  warn_lim_q;

  // memories and their valid bits
  logic [63:0] fast_mem [FAST_DEPTH];
  logic [71:0] grp_mem  [GRP_DEPTH];
  logic [63:0] scl_mem  [BOARD_COUNT];
  logic [63:0] fast_rd_q;
  logic [71:0] grp_rd_q;
  logic [63:0] scl_rd_q;
  logic [GRP_DEPTH-1:0]   row_vld_q;
  logic [GRP_DEPTH-1:0]   grp_vld_q;
  logic [BOARD_COUNT-1:0] scl_vld_q;

  rec_t res_q, exec_rec;
  logic eq_q;
  logic [7:0] cnt_q;
  logic out_valid_q;
  rec_t out_rec_q;

  // decode
  dtype_e      typ;
  logic [5:0]  adc_bidx, info_bidx;
  logic        adc_bok, info_bok, hdr_ok, time_ok;
  logic [3:0]  code, sel;
  logic [19:0] field;
  logic [63:0] cur;
  logic        adc_ok, info_ok, disc_ok, scl_ok;

  logic [BW+5:0] fast_rd_addr, fast_wa;
  logic [BW+1:0] grp_addr, disc_row;
  logic [BW-1:0] scl_addr;
  logic          fast_we;
  logic [63:0]   fast_wd;

  logic [63:0] fast_val, glast, diff, scl_old, scl_new;
  logic [7:0]  gcnt, newcnt;
  logic        eq;
  logic [23:0] prod;

  always_comb begin
    typ       = dtype_e'(wa_q[31:30]);
    adc_bidx  = wa_q[27:22];
    info_bidx = wa_q[29:24];
    adc_bok   = {1'b0, adc_bidx} < 7'(BOARD_COUNT);
    info_bok  = {1'b0, info_bidx} < 7'(BOARD_COUNT);
    code      = wa_q[23:20];
    field     = wa_q[19:0];
    sel       = wa_q[19:16];
    hdr_ok    = (wa_q[31:16] == TAG_A) && (wb_q[31:16] == TAG_B) &&
                (wc_q[31:16] == TAG_C) && (wd_q[31:16] == TAG_D);
    time_ok   = (wb_q[31:28] == 4'd0);
    cur       = {rt_q[63:28], wb_q[27:0]};
    adc_ok    = (op_q != OP_HEADER) && time_ok && (typ == TYPE_ADC) && adc_bok;
    info_ok   = (op_q != OP_HEADER) && time_ok && (typ == TYPE_INFO) && info_bok;
    disc_ok   = info_ok && (code == INFO_DISC) && (sel[3:2] == 2'd0);
    scl_ok    = info_ok && (code == INFO_SCALER) && (sel[3:2] == 2'd0);

    fast_rd_addr = {adc_bidx[BW-1:0], wa_q[21:16]};
    grp_addr     = {adc_bidx[BW-1:0], wa_q[21:20]};
    disc_row     = {info_bidx[BW-1:0], sel[1:0]};
    scl_addr     = info_bidx[BW-1:0];
  end

  always_comb begin
    fast_val = row_vld_q[grp_addr] ? fast_rd_q : 64'd0;
    glast    = grp_vld_q[grp_addr] ? grp_rd_q[71:8] : 64'd0;
    gcnt     = grp_vld_q[grp_addr] ? grp_rd_q[7:0] : 8'd0;
    diff     = cur - glast;
    eq       = (glast != 64'd0) && (diff == {48'd0, spacing_q});
    if (glast == 64'd0) newcnt = gcnt;
    else if (eq) newcnt = (gcnt == 8'hff) ? gcnt : gcnt + 8'd1;
    else newcnt = 8'd0;

    scl_old = scl_vld_q[scl_addr] ? scl_rd_q : 64'd0;
    scl_new = scl_old;
    case (sel[1:0])
      2'd0:    scl_new[15:0]  = field[15:0];
      2'd1:    scl_new[31:16] = field[15:0];
      2'd2:    scl_new[47:32] = field[15:0];
      default: scl_new[63:48] = field[15:0];
    endcase
  end

  // one result per item, running time update
  always_comb begin
    exec_rec = '0;
    rt_d     = rt_q;
    if (op_q == OP_HEADER) begin
      if (hdr_ok) rt_d = {wd_q[15:0], wc_q[15:0], wb_q[15:0], wa_q[15:0]};
      else exec_rec.err = ERR_HEADER;
    end else if (!time_ok) begin
      exec_rec.err = ERR_TIME;
    end else begin
      case (typ)
        TYPE_ADC: begin
          if (!adc_bok) begin
            exec_rec.err = ERR_BOARD;
          end else begin
            rt_d                = cur;
            exec_rec.kind       = KIND_ADC;
            exec_rec.raw_time   = cur;
            exec_rec.slow_time  = cur;
            exec_rec.disc_time  = fast_val;
            exec_rec.value      = {48'd0, wa_q[15:0]};
            exec_rec.board      = {1'b0, adc_bidx} + 7'd1;
            exec_rec.channel    = wa_q[21:16];
            exec_rec.vernier    = wa_q[29];
            exec_rec.gain_range = wa_q[28];
          end
        end
        TYPE_WAVE: exec_rec.err = ERR_WAVE;
        TYPE_INFO: begin
          if (!info_bok) begin
            exec_rec.err = ERR_BOARD;
          end else begin
            case (code)
              INFO_PAUSE, INFO_RESUME, INFO_MID: begin
                rt_d = {cur[63:48], field, wb_q[27:0]};
                if (code != INFO_MID) begin
                  exec_rec.kind     = KIND_FLOW;
                  exec_rec.raw_time = rt_d;
                  exec_rec.board    = {1'b0, info_bidx} + 7'd1;
                  exec_rec.paused   = (code == INFO_PAUSE);
                end
              end
              INFO_HIGH: rt_d = {field[15:0], cur[47:0]};
              INFO_DISC: rt_d = cur;
              INFO_SCALER: begin
                rt_d = cur;
                if (scl_ok && sel[1:0] == SCALER_REPORT_SLOT) begin
                  exec_rec.kind     = KIND_SCALER;
                  exec_rec.raw_time = cur;
                  exec_rec.value    = scl_new;
                  exec_rec.board    = {1'b0, info_bidx} + 7'd1;
                end
              end
              default: exec_rec.err = ERR_CODE;
            endcase
          end
        end
        default: exec_rec.err = ERR_TYPE;
      endcase
    end
  end

  // fast-time write port: clear on adc hit, fill during discriminator sweep
  always_comb begin
    fast_we = 1'b0;
    fast_wa = fast_rd_addr;
    fast_wd = 64'd0;
    if (cmd_i.exec && adc_ok) begin
      fast_we = 1'b1;
    end else if (cmd_i.sweep) begin
      fast_wa = {disc_row, cmd_i.sweep_idx};
      fast_we = field[cmd_i.sweep_idx] || !row_vld_q[disc_row];
      fast_wd = field[cmd_i.sweep_idx] ? rt_q : 64'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fast_we) fast_mem[fast_wa] <= fast_wd;
    fast_rd_q <= fast_mem[fast_rd_addr];
    if (cmd_i.exec && adc_ok) grp_mem[grp_addr] <= {cur, newcnt};
    grp_rd_q <= grp_mem[grp_addr];
    if (cmd_i.exec && scl_ok) scl_mem[scl_addr] <= scl_new;
    scl_rd_q <= scl_mem[scl_addr];
  end

  assign prod = {8'd0, spacing_q} * {16'd0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      wa_q <= word_a_i;
      wb_q <= word_b_i;
      wc_q <= word_c_i;
      wd_q <= word_d_i;
    end
    if (cmd_i.exec) begin
      res_q <= exec_rec;
      eq_q  <= eq;
      cnt_q <= newcnt;
    end else if (cmd_i.corr) begin
      res_q.slow_time <= eq_q ? res_q.raw_time - {40'd0, prod} : res_q.raw_time;
      res_q.warn      <= eq_q && (cnt_q > warn_lim_q);
    end
    if (cmd_i.load_out) out_rec_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q        <= 64'd0;
      row_vld_q   <= '0;
      grp_vld_q   <= '0;
      scl_vld_q   <= '0;
      spacing_q   <= SPACING_RESET;
      warn_lim_q  <= WARN_LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) rt_q <= rt_d;
      if (cmd_i.exec && adc_ok) grp_vld_q[grp_addr] <= 1'b1;
      if (cmd_i.exec && scl_ok) scl_vld_q[scl_addr] <= 1'b1;
      if (cmd_i.sweep_last) row_vld_q[disc_row] <= 1'b1;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SPACING:    spacing_q  <= cfg_data_i;
          CFG_WARN_LIMIT: warn_lim_q <= cfg_data_i[7:0];
          default:        spacing_q  <= spacing_q;
        endcase
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.adc_ok   = adc_ok;
  assign stat_o.disc_ok  = disc_ok;
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_rec_o       = out_rec_q;

endmodule
`default_nettype wire

[verif/tb_top.sv]
module tb_top;
  import dhtu_pkg::*;

  typedef struct {
    logic        opcode;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;
    logic [31:0] wd;
  } item_t;

  localparam int NBOARD = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [31:0] word_a = '0, word_b = '0, word_c = '0, word_d = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [2:0]  error_code;
  logic        multiplex_warning;
  logic [63:0] raw_time, slow_time, disc_time, value;
  logic [6:0]  board;
  logic [5:0]  channel;
  logic        vernier, gain_range, paused;

  // predictor state
  logic [63:0] run_time;
  logic [63:0] fast_mem [NBOARD*64];
  logic [63:0] grp_last [NBOARD*4];
  logic [7:0]  grp_cnt  [NBOARD*4];
  logic [63:0] scaler_word [NBOARD];
  logic [15:0] spacing;
  logic [7:0]  warn_limit;

  item_t pending_items[$];
  rec_t  expected_recs[$];
  item_t drv_item;
  logic  in_taken = 1'b0;
  logic  quiet = 1'b0;
  logic  hold = 1'b0;
  int    errors = 0;
  int    idle_cycles = 0;

  always #2 clk = ~clk;

  detector_hit_timestamp_unpacker DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .word_a_i(word_a), .word_b_i(word_b),
    .word_c_i(word_c), .word_d_i(word_d),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .record_kind_o(record_kind), .error_code_o(error_code),
    .multiplex_warning_o(multiplex_warning),
    .raw_time_o(raw_time), .slow_time_o(slow_time), .disc_time_o(disc_time),
    .value_o(value), .board_o(board), .channel_o(channel),
    .vernier_o(vernier), .gain_range_o(gain_range), .paused_o(paused)
  );

  task automatic unpack_item(input item_t it, output rec_t r);
    logic [63:0] cur, corr, w;
    logic [5:0]  bd, ch;
    logic [3:0]  code, sel;
    logic [19:0] field;
    logic [9:0]  fi;
    logic [5:0]  gi;
    r = '0;
    if (it.opcode == OP_HEADER) begin
      if (it.wa[31:16] != TAG_A || it.wb[31:16] != TAG_B ||
          it.wc[31:16] != TAG_C || it.wd[31:16] != TAG_D) begin
        r.err = ERR_HEADER;
      end else begin
        run_time = {it.wd[15:0], it.wc[15:0], it.wb[15:0], it.wa[15:0]};
      end
      return;
    end
    if (it.wb[31:28] != 4'd0) begin
      r.err = ERR_TIME;
      return;
    end
    cur = {run_time[63:28], it.wb[27:0]};
    case (dtype_e'(it.wa[31:30]))
      TYPE_ADC: begin
        bd = it.wa[27:22];
        ch = it.wa[21:16];
        if (bd >= NBOARD) begin
          r.err = ERR_BOARD;
          return;
        end
        fi = {bd[3:0], ch};
        gi = {bd[3:0], ch[5:4]};
        r.disc_time = fast_mem[fi];
        fast_mem[fi] = '0;
        corr = cur;
        if (grp_last[gi] != 0) begin
          if (cur - grp_last[gi] == {48'd0, spacing}) begin
            if (grp_cnt[gi] != 8'd255) grp_cnt[gi]++;
            corr = cur - {48'd0, spacing} * {56'd0, grp_cnt[gi]};
            r.warn = grp_cnt[gi] > warn_limit;
          end else begin
            grp_cnt[gi] = '0;
          end
        end
        grp_last[gi] = cur;
        run_time = cur;
        r.kind = KIND_ADC;
        r.raw_time = cur;
        r.slow_time = corr;
        r.value = {48'd0, it.wa[15:0]};
        r.board = {1'b0, bd} + 7'd1;
        r.channel = ch;
        r.vernier = it.wa[29];
        r.gain_range = it.wa[28];
      end
      TYPE_WAVE: r.err = ERR_WAVE;
      TYPE_INVALID: r.err = ERR_TYPE;
      default: begin
        bd = it.wa[29:24];
        code = it.wa[23:20];
        field = it.wa[19:0];
        sel = field[19:16];
        if (bd >= NBOARD) begin
          r.err = ERR_BOARD;
          return;
        end
        case (code)
          INFO_PAUSE, INFO_RESUME, INFO_MID: begin
            cur = {cur[63:48], field, it.wb[27:0]};
            run_time = cur;
            if (code != INFO_MID) begin
              r.kind = KIND_FLOW;
              r.raw_time = cur;
              r.board = {1'b0, bd} + 7'd1;
              r.paused = (code == INFO_PAUSE);
            end
          end
          INFO_HIGH: run_time = {field[15:0], cur[47:0]};
          INFO_DISC: begin
            run_time = cur;
            if (sel < 4) begin
              for (int i = 0; i < 16; i++)
                if (field[i]) fast_mem[{bd[3:0], sel[1:0], i[3:0]}] = cur;
            end
          end
          INFO_SCALER: begin
            run_time = cur;
            if (sel < 4) begin
              w = scaler_word[bd[3:0]];
              w[sel[1:0]*16 +: 16] = field[15:0];
              scaler_word[bd[3:0]] = w;
              if (sel[1:0] == SCALER_REPORT_SLOT) begin
                r.kind = KIND_SCALER;
                r.raw_time = cur;
                r.value = w;
                r.board = {1'b0, bd} + 7'd1;
              end
            end
          end
          default: r.err = ERR_CODE;
        endcase
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // input and output acceptance, prediction, comparison, watchdog
  always @(posedge clk) begin
    rec_t er;
    rec_t pr;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        unpack_item(drv_item, pr);
        expected_recs.push_back(pr);
      end
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          er = expected_recs.pop_front();
          check_field("record_kind", er.kind, record_kind);
          check_field("error_code", er.err, error_code);
          check_field("multiplex_warning", er.warn, multiplex_warning);
          check_field("raw_time", er.raw_time, raw_time);
          check_field("slow_time", er.slow_time, slow_time);
          check_field("disc_time", er.disc_time, disc_time);
          check_field("value", er.value, value);
          check_field("board", er.board, board);
          check_field("channel", er.channel, channel);
          check_field("vernier", er.vernier, vernier);
          check_field("gain_range", er.gain_range, gain_range);
          check_field("paused", er.paused, paused);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** detector_hit_timestamp_unpacker: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && !hold && (quiet || $urandom_range(99) >= 8)) begin
          drv_item = pending_items.pop_front();
          in_valid <= 1'b1;
          opcode <= drv_item.opcode;
          word_a <= drv_item.wa;
          word_b <= drv_item.wb;
          word_c <= drv_item.wc;
          word_d <= drv_item.wd;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  function automatic item_t mk_header(input logic [63:0] t);
    item_t it;
    it.opcode = OP_HEADER;
    it.wa = {TAG_A, t[15:0]};
    it.wb = {TAG_B, t[31:16]};
    it.wc = {TAG_C, t[47:32]};
    it.wd = {TAG_D, t[63:48]};
    return it;
  endfunction

  function automatic item_t mk_data(input logic [31:0] wa, input logic [31:0] wb);
    item_t it;
    it.opcode = ~OP_HEADER;
    it.wa = wa;
    it.wb = wb;
    it.wc = $urandom;
    it.wd = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] adc_word(input logic [5:0] bd, input logic [5:0] ch);
    return {TYPE_ADC, 1'($urandom), 1'($urandom), bd, ch, 16'($urandom)};
  endfunction

  function automatic logic [31:0] info_word(input logic [5:0] bd, input logic [3:0] code,
                                            input logic [19:0] field);
    return {TYPE_INFO, bd, code, field};
  endfunction

  // mostly the first few boards so fast times and groups get reused
  function automatic logic [5:0] pick_board();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 6'($urandom_range(3));
    if (r < 92) return 6'($urandom_range(NBOARD - 1));
    return 6'($urandom_range(63, NBOARD));
  endfunction

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPACING) spacing = data;
    else warn_limit = data[7:0];
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_recs.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_directed();
    item_t it;
    pending_items.push_back(mk_header(64'h0));
    pending_items.push_back(mk_header('1));
    pending_items.push_back(mk_header(64'h0000_1234_0000_0000));
    for (int k = 0; k < 4; k++) begin
      it = mk_header(64'($urandom));
      case (k)
        0: it.wa[31:16] = ~TAG_A;
        1: it.wb[31:16] = 16'hffff;
        2: it.wc[31:16] = 16'h0;
        default: it.wd[31:16] = TAG_A;
      endcase
      pending_items.push_back(it);
    end
    pending_items.push_back(mk_data(adc_word(6'd0, 6'd0), 32'hf000_0000));
    pending_items.push_back(mk_data(info_word(6'd0, INFO_DISC, 20'h0_ffff), 32'h0fff_ffff));
    pending_items.push_back(mk_data(info_word(6'd0, INFO_DISC, 20'h4_ffff), 32'h0000_0010));
    pending_items.push_back(mk_data(adc_word(6'd0, 6'd5), 32'h0fff_ffff));
    pending_items.push_back(mk_data(adc_word(6'd15, 6'd63), 32'h0000_0001));
    pending_items.push_back(mk_data(adc_word(6'd16, 6'd0), 32'h0000_0001));
    pending_items.push_back(mk_data(adc_word(6'd63, 6'd63), 32'h0000_0001));
    pending_items.push_back(mk_data({TYPE_WAVE, 30'($urandom)}, 32'h5));
    pending_items.push_back(mk_data({TYPE_INVALID, 30'($urandom)}, 32'h5));
    pending_items.push_back(mk_data(info_word(6'd1, INFO_PAUSE, 20'hfffff), 32'h0abc_def0));
    pending_items.push_back(mk_data(info_word(6'd1, INFO_RESUME, 20'h00001), 32'h1));
    pending_items.push_back(mk_data(info_word(6'd15, INFO_MID, 20'h12345), 32'h2));
    pending_items.push_back(mk_data(info_word(6'd2, INFO_HIGH, 20'hfffff), 32'h3));
    for (int s = 0; s < 5; s++)
      pending_items.push_back(mk_data(info_word(6'd3, INFO_SCALER,
                                      {4'(s == 4 ? 15 : s), 16'($urandom)}), 32'h4));
    pending_items.push_back(mk_data(info_word(6'd0, 4'd0, 20'h0), 32'h5));
    pending_items.push_back(mk_data(info_word(6'd0, 4'd15, 20'hfffff), 32'h5));
    pending_items.push_back(mk_data(info_word(6'd63, INFO_PAUSE, 20'h0), 32'h5));
  endtask

  // groups of hits at multiples of the spacing so correction is exercised
  task automatic add_multiplex_run(input int len, input logic [5:0] bd,
                                   input logic [1:0] grp);
    logic [27:0] base;
    base = 28'($urandom_range(1, 20'hfffff));
    for (int k = 0; k < len; k++)
      pending_items.push_back(mk_data(adc_word(bd, {grp, 4'($urandom)}),
                                      {4'd0, 28'(base + k * spacing)}));
  endtask

  task automatic add_random(input int n);
    int r;
    int cnt;
    item_t it;
    logic [3:0] code;
    logic [31:0] wb;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      wb = {4'd0, 28'($urandom)};
      if ($urandom_range(99) < 4) wb = $urandom;
      if (r < 8) begin
        pending_items.push_back(mk_header({$urandom, $urandom}));
        cnt++;
      end else if (r < 11) begin
        it = mk_header({$urandom, $urandom});
        case ($urandom_range(3))
          0: it.wa = $urandom;
          1: it.wb = $urandom;
          2: it.wc = $urandom;
          default: it.wd = $urandom;
        endcase
        pending_items.push_back(it);
        cnt++;
      end else if (r < 25) begin
        add_multiplex_run($urandom_range(2, 22), 6'($urandom_range(3)),
                          2'($urandom));
        cnt += 10;
      end else if (r < 50) begin
        pending_items.push_back(mk_data(adc_word(pick_board(), 6'($urandom)), wb));
        cnt++;
      end else if (r < 92) begin
        case ($urandom_range(9))
          0: code = INFO_PAUSE;
          1: code = INFO_RESUME;
          2: code = INFO_MID;
          3: code = INFO_HIGH;
          4, 5: code = INFO_DISC;
          6, 7: code = INFO_SCALER;
          default: code = 4'($urandom);
        endcase
        it = mk_data(info_word(pick_board(), code, 20'($urandom)), wb);
        if ((code == INFO_DISC || code == INFO_SCALER) && $urandom_range(9) < 8)
          it.wa[19:18] = 2'b00;
        pending_items.push_back(it);
        cnt++;
      end else begin
        pending_items.push_back(mk_data({1'b0, 31'($urandom)}, wb));
        cnt++;
      end
    end
  endtask

  initial begin
    run_time = '0;
    foreach (fast_mem[i]) fast_mem[i] = '0;
    foreach (grp_last[i]) grp_last[i] = '0;
    foreach (grp_cnt[i]) grp_cnt[i] = '0;
    foreach (scaler_word[i]) scaler_word[i] = '0;
    spacing = SPACING_RESET;
    warn_limit = WARN_LIMIT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_directed();
    add_random(100);
    wait_drained();

    write_cfg(CFG_SPACING, 16'd0);
    write_cfg(CFG_WARN_LIMIT, 16'd0);
    // equal times back to back drive the group count into saturation
    add_multiplex_run(262, 6'd1, 2'd2);
    add_random(80);
    wait_drained();

    write_cfg(CFG_SPACING, 16'hffff);
    write_cfg(CFG_WARN_LIMIT, 16'h00ff);
    quiet = 1'b1;
    add_random(100);
    wait_drained();
    quiet = 1'b0;

    write_cfg(CFG_SPACING, 16'($urandom));
    write_cfg(CFG_WARN_LIMIT, 16'($urandom_range(1, 20)));
    add_random(70);
    // sender holds off until everything so far has come out
    while (pending_items.size() > 60) @(posedge clk);
    hold = 1'b1;
    while (in_valid || expected_recs.size() != 0) @(posedge clk);
    hold = 1'b0;
    wait_drained();

    write_cfg(CFG_SPACING, 16'd7);
    write_cfg(CFG_WARN_LIMIT, 16'd3);
    add_random(100);
    wait_drained();

    if (errors == 0 && expected_recs.size() == 0) begin
      $display("** detector_hit_timestamp_unpacker: PASSED **");
    end else begin
      $display("** detector_hit_timestamp_unpacker: FAILED **");
    end
    $finish;
  end

endmodule
